// ===== hw/rtl/lcim_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the LED chain index map.
// No dependencies; imported by every module of the block.
package lcim_pkg;

	localparam int COORD_BITS    = 8;
	localparam int IDX_BITS      = 16;
	localparam int PROD_BITS     = 2 * COORD_BITS;
	localparam int SUM_BITS      = ((PROD_BITS > IDX_BITS) ? PROD_BITS : IDX_BITS) + 2;
	localparam int CFG_IDX_BITS  = 3;
	// edges from request acceptance to the done strobe of its result
	localparam int PIPE_LATENCY  = COORD_BITS + 4;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_MATRIX_WIDTH     = 3'd0,
		CFG_MATRIX_HEIGHT    = 3'd1,
		CFG_SEGMENT_WIDTH    = 3'd2,
		CFG_WIRING_DIRECTION = 3'd3,
		CFG_SNAKE_FLOW       = 3'd4,
		CFG_ORIGIN_CORNER    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pixel_req_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] led_index;
		logic                out_of_range;
	} map_rsp_t;

	// decoded configuration as seen by the datapath
	typedef struct packed {
		logic [COORD_BITS-1:0] matrix_width;
		logic [COORD_BITS-1:0] matrix_height;
		logic [COORD_BITS-1:0] seg_width;   // never zero
		logic                  row_wise;
		logic                  snake;
		logic                  mirror_x;
		logic                  mirror_y;
	} cfg_t;

	// mirrored coordinate travelling down the pipe
	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic                  oor;
	} coord_t;

endpackage

// ===== hw/rtl/lcim_cfg_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file and decode for the LED chain index map.
// Depends on lcim_pkg.
module lcim_cfg_regs
	import lcim_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_valid,
	input  logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]   cfg_data,
	output cfg_t                    cfg
);

	logic [COORD_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] height_q;
	logic [COORD_BITS-1:0] seg_width_q;
	logic [1:0]            direction_q;
	logic                  snake_q;
	logic [1:0]            origin_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= COORD_BITS'(16);
			height_q    <= COORD_BITS'(16);
			seg_width_q <= COORD_BITS'(16);
			direction_q <= 2'd0;
			snake_q     <= 1'b1;
			origin_q    <= 2'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MATRIX_WIDTH:     width_q     <= cfg_data;
				CFG_MATRIX_HEIGHT:    height_q    <= cfg_data;
				CFG_SEGMENT_WIDTH:    seg_width_q <= cfg_data;
				CFG_WIRING_DIRECTION: direction_q <= cfg_data[1:0];
				CFG_SNAKE_FLOW:       snake_q     <= cfg_data[0];
				CFG_ORIGIN_CORNER:    origin_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.matrix_width  = width_q;
		cfg.matrix_height = height_q;
		// zero segment width acts as one
		cfg.seg_width     = (seg_width_q == '0) ? COORD_BITS'(1) : seg_width_q;
		// right/left are row-wise, down/up column-wise
		cfg.row_wise      = !direction_q[1];
		cfg.snake         = snake_q;
		cfg.mirror_x      = origin_q[0];
		cfg.mirror_y      = origin_q[1];
	end

endmodule

// ===== hw/rtl/lcim_front.sv =====
`timescale 1ns / 1ps
// Input stage: range check and origin-corner mirroring of the coordinate.
// Depends on lcim_pkg.
module lcim_front
	import lcim_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_vld,
	input  pixel_req_t pixel,
	output logic       vld_s1,
	output coord_t     item_s1
);

	coord_t item_d;

	always_comb begin
		item_d.oor = (pixel.pixel_x >= cfg.matrix_width) ||
		             (pixel.pixel_y >= cfg.matrix_height);
		item_d.x   = cfg.mirror_x ? (cfg.matrix_width - COORD_BITS'(1) - pixel.pixel_x)
		                          : pixel.pixel_x;
		item_d.y   = cfg.mirror_y ? (cfg.matrix_height - COORD_BITS'(1) - pixel.pixel_y)
		                          : pixel.pixel_y;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item_d;
	end

endmodule

// ===== hw/rtl/lcim_rem_pipe.sv =====
`timescale 1ns / 1ps
// Pipelined restoring division: x mod segment width, one quotient bit per stage.
// Depends on lcim_pkg.
module lcim_rem_pipe
	import lcim_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_vld,
	input  coord_t                in_item,
	output logic                  out_vld,
	output coord_t                out_item,
	output logic [COORD_BITS-1:0] out_rem,
	output logic                  occupied
);

	logic [COORD_BITS-1:0] vld_s;
	coord_t                item_s    [COORD_BITS];
	logic [COORD_BITS-1:0] rem_s     [COORD_BITS];

	logic [COORD_BITS-1:0] vld_prev;
	coord_t                item_prev [COORD_BITS];
	logic [COORD_BITS-1:0] rem_prev  [COORD_BITS];
	logic [COORD_BITS:0]   trial     [COORD_BITS];
	logic [COORD_BITS:0]   diff      [COORD_BITS];
	logic [COORD_BITS-1:0] rem_next  [COORD_BITS];

	always_comb begin
		for (int k = 0; k < COORD_BITS; k++) begin
			if (k == 0) begin
				vld_prev[k]  = in_vld;
				item_prev[k] = in_item;
				rem_prev[k]  = '0;
			end else begin
				vld_prev[k]  = vld_s[k-1];
				item_prev[k] = item_s[k-1];
				rem_prev[k]  = rem_s[k-1];
			end
			// shift in the next dividend bit, MSB first
			trial[k] = {rem_prev[k], item_prev[k].x[COORD_BITS-1-k]};
			diff[k]  = trial[k] - {1'b0, cfg.seg_width};
			rem_next[k] = (trial[k] >= {1'b0, cfg.seg_width}) ? diff[k][COORD_BITS-1:0]
			                                                    : trial[k][COORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= vld_prev;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < COORD_BITS; k++) begin
			item_s[k] <= item_prev[k];
			rem_s[k]  <= rem_next[k];
		end
	end

	assign out_vld  = vld_s[COORD_BITS-1];
	assign out_item = item_s[COORD_BITS-1];
	assign out_rem  = rem_s[COORD_BITS-1];
	assign occupied = |vld_s;

endmodule

// ===== hw/rtl/lcim_back.sv =====
`timescale 1ns / 1ps
// Chain position: operand select, two multiplies, final sum and result register.
// Depends on lcim_pkg.
module lcim_back
	import lcim_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  cfg_t                  cfg,
	input  logic                  in_vld,
	input  coord_t                in_item,
	input  logic [COORD_BITS-1:0] in_rem,
	output logic                  done,
	output map_rsp_t              result,
	output logic                  occupied
);

	logic [COORD_BITS-1:0] mul_a_d;
	logic [COORD_BITS-1:0] mul_b_d;
	logic [COORD_BITS-1:0] off_d;

	logic                  vld_s1;
	logic                  oor_s1;
	logic [COORD_BITS-1:0] mul_a_s1;
	logic [COORD_BITS-1:0] mul_b_s1;
	logic [COORD_BITS-1:0] off_s1;

	logic                  vld_s2;
	logic                  oor_s2;
	logic [PROD_BITS-1:0]  p1_s2;
	logic [PROD_BITS-1:0]  p2_s2;
	logic [COORD_BITS-1:0] off_s2;

	logic [SUM_BITS-1:0]   sum_d;
	logic                  done_s3;
	map_rsp_t              result_s3;

	// row-wise: (x - within)*h + y*sw + within'; column-wise: x*h + y'
	always_comb begin
		if (cfg.row_wise) begin
			mul_a_d = in_item.x - in_rem;
			mul_b_d = in_item.y;
			off_d   = (cfg.snake && in_item.y[0])
			          ? (cfg.seg_width - COORD_BITS'(1) - in_rem) : in_rem;
		end else begin
			mul_a_d = in_item.x;
			mul_b_d = '0;
			off_d   = (cfg.snake && in_item.x[0])
			          ? (cfg.matrix_height - COORD_BITS'(1) - in_item.y) : in_item.y;
		end
	end

	assign sum_d = SUM_BITS'(p1_s2) + SUM_BITS'(p2_s2) + SUM_BITS'(off_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			vld_s1  <= in_vld;
			vld_s2  <= vld_s1;
			done_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		oor_s1   <= in_item.oor;
		mul_a_s1 <= mul_a_d;
		mul_b_s1 <= mul_b_d;
		off_s1   <= off_d;

		oor_s2   <= oor_s1;
		p1_s2    <= PROD_BITS'(mul_a_s1) * PROD_BITS'(cfg.matrix_height);
		p2_s2    <= PROD_BITS'(mul_b_s1) * PROD_BITS'(cfg.seg_width);
		off_s2   <= off_s1;

		result_s3.out_of_range <= oor_s2;
		result_s3.led_index    <= oor_s2 ? '0 : sum_d[IDX_BITS-1:0];
	end

	assign done     = done_s3;
	assign result   = result_s3;
	assign occupied = vld_s1 | vld_s2 | done_s3;

endmodule

// ===== hw/rtl/led_matrix_chain_index_map_unit.sv =====
`timescale 1ns / 1ps
// Top level of the LED chain index map: coordinate in, chain position out.
// Depends on lcim_pkg, lcim_cfg_regs, lcim_front, lcim_rem_pipe, lcim_back.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------
//  request  | start / busy         | pixel  (pixel_x, pixel_y)
//  result   | done (1-cycle strobe)| result (led_index, out_of_range)
//  config   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One request per cycle while busy is low; each result passes the front
// register, the one-bit-per-stage remainder pipe and back stages s1 to s3.
// busy is high during reset and the first cycle after it; the pipe never stalls
// since results cannot be held off. cfg_ready is low while a request is taken
// or still in flight.
module led_matrix_chain_index_map_unit
	import lcim_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  pixel_req_t              pixel,
	output logic                    done,
	output map_rsp_t                result,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [COORD_BITS-1:0]   cfg_data
);

	cfg_t                  cfg;
	logic                  busy_q;
	logic                  accept;
	logic                  front_vld;
	coord_t                front_item;
	logic                  rem_vld;
	coord_t                rem_item;
	logic [COORD_BITS-1:0] rem_val;
	logic                  rem_occupied;
	logic                  back_occupied;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
		end else begin
			busy_q <= 1'b0;
		end
	end

	assign busy      = busy_q;
	assign accept    = start && !busy_q;
	assign cfg_ready = !(accept || front_vld || rem_occupied || back_occupied);

	lcim_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	lcim_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.in_vld  (accept),
		.pixel   (pixel),
		.vld_s1  (front_vld),
		.item_s1 (front_item)
	);

	lcim_rem_pipe u_rem (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_vld   (front_vld),
		.in_item  (front_item),
		.out_vld  (rem_vld),
		.out_item (rem_item),
		.out_rem  (rem_val),
		.occupied (rem_occupied)
	);

	lcim_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_vld   (rem_vld),
		.in_item  (rem_item),
		.in_rem   (rem_val),
		.done     (done),
		.result   (result),
		.occupied (back_occupied)
	);

endmodule

// ===== hw/rtl/lcim_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks of the LED chain index map, bound to the top level.
// Depends on lcim_pkg and led_matrix_chain_index_map_unit.
module lcim_checker
	import lcim_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  logic     done,
	input  map_rsp_t result,
	input  logic     cfg_valid,
	input  logic     cfg_ready
);

	// every request yields exactly one result at fixed latency
	a_req_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##(PIPE_LATENCY) done)
		else $error("request without result at pipe latency");

	a_rsp_from_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LATENCY))
		else $error("result without matching request");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.out_of_range) |-> (result.led_index == '0))
		else $error("out-of-range result with nonzero index");

	// config is never taken while done is high
	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready) |-> !done)
		else $error("config write accepted while a result is pending");

endmodule

bind led_matrix_chain_index_map_unit lcim_checker u_lcim_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.result    (result),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
